/* rtl/core/gn3d_pkg.sv */
// Package for the 3D gradient noise pipeline.
// Holds the permutation table and the gradient selection function.
// No dependencies.
package gn3d_pkg;

  localparam int COORD_W = 32;
  localparam int NOISE_W = 18;

  function automatic logic [7:0] perm_lut(input logic [7:0] idx);
    logic [7:0] r;
    case (idx)
      8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
      8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
      8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
      8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
      8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
      8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
      8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
      8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
      8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
      8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
      8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
      8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
      8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
      8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
      8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
      8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
      8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
      8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
      8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
      8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
      8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
      8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
      8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
      8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
      8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
      8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
      8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
      8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
      8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
      8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
      8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
      8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
      8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
      8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
      8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
      8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
      8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
      8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
      8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
      8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
      8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
      8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
      8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
      8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
      8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
      8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
      8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
      8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
      8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
      8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
      8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
      8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
      8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
      8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
      8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
      8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
      8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
      8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
      8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
      8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
      8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
      8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
      8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
      8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Gradient codes that reuse x as the second term.
  localparam logic [3:0] GRAD_C12 = 4'd12;
  localparam logic [3:0] GRAD_C14 = 4'd14;

  // Selects which offsets form the dot product for one corner.
  // u_is_y: 0 picks x, 1 picks y. v_sel: 0 y, 1 x, 2 z.
  typedef struct packed {
    logic       u_is_y;
    logic [1:0] v_sel;
    logic       neg_u;
    logic       neg_v;
  } grad_ctl_t;

  localparam logic [1:0] VSEL_Y = 2'd0;
  localparam logic [1:0] VSEL_X = 2'd1;
  localparam logic [1:0] VSEL_Z = 2'd2;

  function automatic grad_ctl_t grad_decode(input logic [3:0] h);
    grad_ctl_t g;
    g.u_is_y = (h >= 4'd8);
    if (h < 4'd4) begin
      g.v_sel = VSEL_Y;
    end else if (h == GRAD_C12 || h == GRAD_C14) begin
      g.v_sel = VSEL_X;
    end else begin
      g.v_sel = VSEL_Z;
    end
    g.neg_u = h[0];
    g.neg_v = h[1];
    return g;
  endfunction

endpackage

/* rtl/core/gn3d_fade.sv */
// Pipelined quintic fade curve for one axis fraction.
// Depends on gn3d_pkg; four multiply stages, one register after each.
module gn3d_fade import gn3d_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] t_in,
  output logic [FRAC_BITS:0]   f_out
);

  localparam int W = FRAC_BITS + 6;
  localparam logic signed [W-1:0] ONE15 = W'(15) <<< FRAC_BITS;
  localparam logic signed [W-1:0] ONE10 = W'(10) <<< FRAC_BITS;

  logic [FRAC_BITS-1:0] t1_r, t2_r, t3_r;
  logic signed [W-1:0]  b1_r, b2_r, b3_r;
  logic [FRAC_BITS:0]   f_r;

  logic signed [W-1:0]     a_c;
  logic signed [2*W+1:0]   p1, p2, p3, p4;
  logic signed [W-1:0]     b1_nxt;

  always_comb begin
    a_c    = W'(6) * $signed({6'd0, t_in}) - ONE15;
    p1     = $signed({1'b0, t_in}) * a_c;
    b1_nxt = W'(p1 >>> FRAC_BITS) + ONE10;
    p2     = $signed({1'b0, t1_r}) * b1_r;
    p3     = $signed({1'b0, t2_r}) * b2_r;
    p4     = $signed({1'b0, t3_r}) * b3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t_in;
      b1_r <= b1_nxt;
      t2_r <= t1_r;
      b2_r <= W'(p2 >>> FRAC_BITS);
      t3_r <= t2_r;
      b3_r <= W'(p3 >>> FRAC_BITS);
      f_r  <= (FRAC_BITS+1)'(p4 >>> FRAC_BITS);
    end
  end

  assign f_out = f_r;

endmodule

/* rtl/core/gradient_noise_3d.sv */
// Top level of the 3D gradient noise pipeline.
// Depends on gn3d_pkg and gn3d_fade.
//
// Improved 3D gradient noise: each item is a point in signed fixed point
// (FRAC_BITS fraction bits) and yields one Q2.16 sample, saturated to 18 bits.
// The pipeline takes one item every cycle while the output is not stalled; the
// fade curve's four chained multiplies and the three blend levels set its
// depth. A stall on the output holds the entire pipeline in place.
module gradient_noise_3d import gn3d_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // coord_x[31:0], coord_y[63:32], coord_z[95:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata   // noise_value[17:0], zero fill above
);

  localparam int FB = FRAC_BITS;
  localparam int OW = FB + 2;  // corner offsets, signed
  localparam int GW = FB + 3;  // gradient sums, signed
  localparam int NST = 7;

  logic en;
  logic [NST-1:0] vld_r;

  assign en        = !vld_r[NST-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // Input split.
  logic [COORD_W-1:0] cx_in, cy_in, cz_in;
  assign cx_in = in_tdata[31:0];
  assign cy_in = in_tdata[63:32];
  assign cz_in = in_tdata[95:64];

  logic [FB:0] fu, fv, fw;
  gn3d_fade #(.FRAC_BITS(FB)) u_fade_x (.clk, .en, .t_in(cx_in[FB-1:0]), .f_out(fu));
  gn3d_fade #(.FRAC_BITS(FB)) u_fade_y (.clk, .en, .t_in(cy_in[FB-1:0]), .f_out(fv));
  gn3d_fade #(.FRAC_BITS(FB)) u_fade_z (.clk, .en, .t_in(cz_in[FB-1:0]), .f_out(fw));

  // Stage 1: first hash level.
  logic [7:0] a1_r, b1_r, cz1_r;
  logic [FB-1:0] fx1_r, fy1_r, fz1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= perm_lut(cx_in[FB+7:FB]) + cy_in[FB+7:FB];
      b1_r  <= perm_lut(cx_in[FB+7:FB] + 8'd1) + cy_in[FB+7:FB];
      cz1_r <= cz_in[FB+7:FB];
      fx1_r <= cx_in[FB-1:0];
      fy1_r <= cy_in[FB-1:0];
      fz1_r <= cz_in[FB-1:0];
    end
  end

  // Stage 2: second hash level.
  logic [7:0] aa2_r, ab2_r, ba2_r, bb2_r;
  logic [FB-1:0] fx2_r, fy2_r, fz2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      aa2_r <= perm_lut(a1_r) + cz1_r;
      ab2_r <= perm_lut(a1_r + 8'd1) + cz1_r;
      ba2_r <= perm_lut(b1_r) + cz1_r;
      bb2_r <= perm_lut(b1_r + 8'd1) + cz1_r;
      fx2_r <= fx1_r;
      fy2_r <= fy1_r;
      fz2_r <= fz1_r;
    end
  end

  // Stage 3: corner hashes and gradient dot products.
  // Corner bit 0 picks x1, bit 1 picks y1, bit 2 picks z1.
  logic [7:0] idx3 [8];
  logic signed [GW-1:0] g_nxt [8];
  always_comb begin
    logic signed [OW-1:0] ox, oy, oz, uu, vv;
    grad_ctl_t gc;
    logic [7:0] hv;
    idx3[0] = aa2_r;         idx3[1] = ba2_r;
    idx3[2] = ab2_r;         idx3[3] = bb2_r;
    idx3[4] = aa2_r + 8'd1;  idx3[5] = ba2_r + 8'd1;
    idx3[6] = ab2_r + 8'd1;  idx3[7] = bb2_r + 8'd1;
    for (int k = 0; k < 8; k++) begin
      ox = $signed({2'b00, fx2_r}) - (k[0] ? $signed(OW'(1) << FB) : '0);
      oy = $signed({2'b00, fy2_r}) - (k[1] ? $signed(OW'(1) << FB) : '0);
      oz = $signed({2'b00, fz2_r}) - (k[2] ? $signed(OW'(1) << FB) : '0);
      hv = perm_lut(idx3[k]);
      gc = grad_decode(hv[3:0]);
      uu = gc.u_is_y ? oy : ox;
      case (gc.v_sel)
        VSEL_Y:  vv = oy;
        VSEL_X:  vv = ox;
        default: vv = oz;
      endcase
      g_nxt[k] = (gc.neg_u ? -GW'(uu) : GW'(uu)) + (gc.neg_v ? -GW'(vv) : GW'(vv));
    end
  end

  logic signed [GW-1:0] g3_r [8];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) g3_r[k] <= g_nxt[k];
    end
  end

  // The gradients wait one stage so that they meet the fade results.
  logic signed [GW-1:0] g4_r [8];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) g4_r[k] <= g3_r[k];
    end
  end

  // Fade result arrives at stage 4; blends along x, then y, then z.
  localparam int LW = FB + 4;
  function automatic logic signed [LW-1:0] lerp(input logic [FB:0] f,
                                                input logic signed [LW-1:0] a,
                                                input logic signed [LW-1:0] b);
    logic signed [2*LW+1:0] p;
    p = $signed({1'b0, f}) * (b - a);
    return a + LW'(p >>> FB);
  endfunction

  logic signed [LW-1:0] lx4_r [4];
  logic [FB:0] fv4_r, fw4_r, fw5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++)
        lx4_r[k] <= lerp(fu, LW'(g4_r[2*k]), LW'(g4_r[2*k+1]));
      fv4_r <= fv;
      fw4_r <= fw;
    end
  end

  logic signed [LW-1:0] ly5_r [2];
  always_ff @(posedge clk) begin
    if (en) begin
      ly5_r[0] <= lerp(fv4_r, lx4_r[0], lx4_r[1]);
      ly5_r[1] <= lerp(fv4_r, lx4_r[2], lx4_r[3]);
      fw5_r    <= fw4_r;
    end
  end

  // Final blend, scale to 16 fraction bits and saturate.
  logic signed [LW-1:0]  r6;
  logic signed [LW+16:0] rs6;
  logic [NOISE_W-1:0]    out_r;
  always_comb begin
    r6 = lerp(fw5_r, ly5_r[0], ly5_r[1]);
    if (FB >= 16) begin
      rs6 = (LW+17)'(r6 >>> (FB - 16));
    end else begin
      rs6 = (LW+17)'(r6) <<< (16 - FB);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rs6 > (LW+17)'(131071)) begin
        out_r <= 18'h1FFFF;
      end else if (rs6 < -(LW+17)'(131072)) begin
        out_r <= 18'h20000;
      end else begin
        out_r <= rs6[NOISE_W-1:0];
      end
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {6'd0, out_r};

endmodule
